// ----- rtl/core/s256h_pkg.sv -----
// ============================================================================
// s256h_pkg
// Types, constants and a rotate function for the SHA-256 byte stream hasher.
// ============================================================================
`default_nettype none

package s256h_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } s256h_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } s256h_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_EMIT
  } s256h_state_e;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/s256h_ram.sv -----
// ============================================================================
// s256h_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ============================================================================
`default_nettype none

module s256h_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/sha256_byte_stream_hasher.sv -----
// ============================================================================
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, digest out as four 64-bit big-endian beats.
// ============================================================================
// Flow: a byte that does not fill a block is taken without a stall. A full
// block stalls the input through the load, round and final states.
// Padding writes the pad bytes, then runs one or two compressions, then four
// output beats. Throughput is set by the one-round-per-cycle compression.
// Reset: chain value to initial hash, counters to zero; block bytes undefined.
`default_nettype none

module sha256_byte_stream_hasher
  import s256h_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire s256h_in_t  in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output s256h_out_t      out_data_o
);

  s256h_state_e state_q, state_d;

  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [6:0]  cnt_q;
  logic        eom_q;
  logic        pad_first_q;
  logic [63:0] len_q;
  logic [1:0]  oidx_q;
  // done flag: set when the last byte of the block carrying the length is written
  logic        len_done_q;
  // 0x80 landed at offset 56 to 62: this block carries no length
  logic        tail_q;

  // block memory
  logic       ram_we;
  logic [5:0] ram_waddr;
  logic [7:0] ram_wdata;
  logic [5:0] ram_raddr;
  logic [7:0] ram_rdata;

  s256h_ram #(.Width(8), .Depth(64)) u_block (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic in_fire;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  // pad byte for current fill position
  logic [7:0] pad_byte;
  always_comb begin
    if (pad_first_q) begin
      pad_byte = PadByte;
    end else if (fill_q >= LenOffset && !tail_q) begin
      pad_byte = len_q[{~fill_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // byte written into the block this cycle
  logic byte_wr;
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = in_data_i.data_byte;
    ram_waddr = fill_q;
    byte_wr   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_data_i.byte_valid) begin
          ram_we  = 1'b1;
          byte_wr = 1'b1;
        end
      end
      ST_PAD: begin
        ram_we    = 1'b1;
        ram_wdata = pad_byte;
        byte_wr   = 1'b1;
      end
      default: ;
    endcase
  end

  // load: cnt 0..64; read address cnt[5:0], data valid in the next cycle
  assign ram_raddr = cnt_q[5:0];

  // round logic
  logic [31:0] w_new, s0, s1, t1, t2, e, a;
  assign s0    = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1    = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;
  assign e     = v_q[4];
  assign a     = v_q[0];
  assign t1 = v_q[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
            + ((e & v_q[5]) ^ (~e & v_q[6])) + RoundK[cnt_q[5:0]] + w_q[0];
  assign t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
            + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.byte_valid && fill_q == 6'd63) begin
            state_d = ST_LOAD;
          end else if (in_data_i.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_LOAD:  if (cnt_q == 7'd64) state_d = ST_ROUND;
      ST_ROUND: if (cnt_q == 7'd63) state_d = ST_FINAL;
      ST_FINAL: begin
        if (len_done_q) begin
          state_d = ST_EMIT;
        end else if (eom_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD:   if (fill_q == 6'd63) state_d = ST_LOAD;
      ST_EMIT:  if (!out_stall_i && oidx_q == 2'd3) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      bits_q      <= '0;
      cnt_q       <= '0;
      eom_q       <= 1'b0;
      pad_first_q <= 1'b0;
      len_done_q  <= 1'b0;
      tail_q      <= 1'b0;
      oidx_q      <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
    end else begin
      if (byte_wr) begin
        fill_q <= fill_q + 6'd1;
        if (state_q == ST_PAD) begin
          pad_first_q <= 1'b0;
          if (fill_q == 6'd63) begin
            len_done_q <= !(tail_q || pad_first_q);
            tail_q     <= 1'b0;
          end else if (pad_first_q && fill_q >= LenOffset) begin
            tail_q <= 1'b1;
          end
        end
      end
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_fire) begin
            if (in_data_i.byte_valid) bits_q <= bits_q + 64'd8;
            eom_q       <= in_data_i.end_of_message;
            pad_first_q <= in_data_i.end_of_message;
            len_done_q  <= 1'b0;
          end
        end
        ST_LOAD: begin
          cnt_q <= (cnt_q == 7'd64) ? 7'd0 : cnt_q + 7'd1;
        end
        ST_ROUND: begin
          cnt_q <= cnt_q + 7'd1;
        end
        ST_FINAL: begin
          cnt_q <= '0;
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        end
        ST_EMIT: begin
          if (!out_stall_i) begin
            oidx_q <= oidx_q + 2'd1;
            if (oidx_q == 2'd3) begin
              for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
              bits_q <= '0;
              fill_q <= '0;
              eom_q  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_fire && in_data_i.end_of_message) begin
      len_q <= bits_q + (in_data_i.byte_valid ? 64'd8 : 64'd0);
    end
    case (state_q)
      ST_LOAD: begin
        if (cnt_q != 7'd0) begin
          for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
          w_q[15] <= {w_q[15][23:0], ram_rdata};
        end
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= w_new;
        v_q[7] <= v_q[6];
        v_q[6] <= v_q[5];
        v_q[5] <= e;
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2];
        v_q[2] <= v_q[1];
        v_q[1] <= a;
        v_q[0] <= t1 + t2;
      end
      default: ;
    endcase
  end

  assign out_valid_o             = (state_q == ST_EMIT);
  assign out_data_o.digest_word  = {h_q[{oidx_q, 1'b0}], h_q[{oidx_q, 1'b1}]};
  assign out_data_o.word_index   = oidx_q;
  assign out_data_o.last_word    = (oidx_q == 2'd3);

endmodule

`default_nettype wire
